[rtl/core/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg
// shared types, codes and sizes of the card tap classifier
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

  // table and identifier sizes
  localparam int SLOT_COUNT = 4;
  localparam int ID_BYTES   = 7;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 56;
  localparam int LEN_W  = 3;
  localparam int TIME_W = 32;
  localparam int TSLOT_W = 4;
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 16;
  localparam int NUM_CNT = 5;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ID_BYTES);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes on the configuration port
  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_DEBOUNCE = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_RESET   = 16'd2000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd500;

  typedef enum logic [CMD_W-1:0] {
    CMD_NO_CARD     = 3'd0,
    CMD_CARD_READ   = 3'd1,
    CMD_READ_FAILED = 3'd2,
    CMD_REGISTER    = 3'd3,
    CMD_CLEAR_STATS = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_FIRST   = 2'd1,
    EV_DOUBLE  = 2'd2,
    EV_UNKNOWN = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    RS_NONE       = 2'd0,
    RS_REGISTERED = 2'd1,
    RS_BAD_SLOT   = 2'd2,
    RS_DUPLICATE  = 2'd3
  } reg_status_t;

  // led patterns
  localparam logic [2:0] LED_OFF   = 3'b000;
  localparam logic [2:0] LED_RED   = 3'b001;
  localparam logic [2:0] LED_GREEN = 3'b010;
  localparam logic [2:0] LED_BLUE  = 3'b100;

  // counter slots
  localparam int CNT_TOTAL   = 0;
  localparam int CNT_VALID   = 1;
  localparam int CNT_UNKNOWN = 2;
  localparam int CNT_SINGLE  = 3;
  localparam int CNT_DOUBLE  = 4;

endpackage

`default_nettype wire

[rtl/core/card_tap_classifier_core.sv]
// ----------------------------------------------------------------------------
// card_tap_classifier_core
// card poll classifier: debounce, slot lookup, single and double tap events
// ----------------------------------------------------------------------------
// One poll per transfer on the input channel gives one result transfer on the
// output channel. The block takes a new poll every clock cycle while out_stall
// stays low; a poll goes through the input register and then the result
// register before its result can transfer. The rate is set by the single pass
// through the four parallel identifier compares, the three timestamp
// subtractions and the counter update, all between those registers. A result
// that waits on out_stall holds the input register, and in_stall rises only
// when both registers are full. The slot table has no clearing pass: a slot's
// identifier is only looked at once the slot has been registered. The two
// timing registers sit on an APB-style port at byte addresses 0 (double tap
// window) and 4 (debounce time); the user must write them only while no poll
// is in flight, as the block itself does not enforce this.
`default_nettype none

module card_tap_classifier_core
  import ctc_pkg::*;
(
  input  wire  logic                 clk,
  input  wire  logic                 rst,

  // configuration port
  input  wire  logic                 psel,
  input  wire  logic                 penable,
  input  wire  logic                 pwrite,
  input  wire  logic [2:0]           paddr,
  input  wire  logic [31:0]          pwdata,
  output       logic [31:0]          prdata,
  output       logic                 pready,

  // poll channel
  input  wire  logic                 in_valid,
  output       logic                 in_stall,
  input  wire  logic [CMD_W-1:0]     command,
  input  wire  logic [ID_W-1:0]      card_id,
  input  wire  logic [LEN_W-1:0]     card_id_bytes,
  input  wire  logic [TIME_W-1:0]    time_ms,
  input  wire  logic [TSLOT_W-1:0]   target_slot,

  // result channel
  output       logic                 out_valid,
  input  wire  logic                 out_stall,
  output       logic [1:0]           event_res,
  output       logic                 single_confirmed,
  output       logic                 slot_found,
  output       logic [1:0]           matched_slot,
  output       logic [2:0]           leds,
  output       logic [1:0]           register_status,
  output       logic [CNT_W-1:0]     total_reads,
  output       logic [CNT_W-1:0]     valid_reads,
  output       logic [CNT_W-1:0]     unknown_reads,
  output       logic [CNT_W-1:0]     single_taps,
  output       logic [CNT_W-1:0]     double_taps
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] window_ms;
  logic [CFG_W-1:0] debounce_ms;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= WINDOW_RESET;
      debounce_ms <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      // register index is the word address
      if (paddr[2] == REG_WINDOW) begin
        window_ms <= pwdata[CFG_W-1:0];
      end else begin
        debounce_ms <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_DEBOUNCE) begin
      prdata = {{(32-CFG_W){1'b0}}, debounce_ms};
    end else begin
      prdata = {{(32-CFG_W){1'b0}}, window_ms};
    end
  end

  // --------------------------------------------------------------------------
  // input register and flow control
  // --------------------------------------------------------------------------
  logic                 s1_valid;
  logic [CMD_W-1:0]     s1_cmd;
  logic [ID_W-1:0]      s1_id;
  logic [LEN_W-1:0]     s1_len;
  logic [TIME_W-1:0]    s1_time;
  logic [TSLOT_W-1:0]   s1_tslot;
  logic                 advance;
  logic                 accept_in;

  // the held poll moves on when the result register is free or being emptied
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_cmd   <= command;
      s1_id    <= card_id;
      s1_len   <= card_id_bytes;
      s1_time  <= time_ms;
      s1_tslot <= target_slot;
    end
  end

  // --------------------------------------------------------------------------
  // classifier state
  // --------------------------------------------------------------------------
  logic [ID_W-1:0]   slot_id     [SLOT_COUNT];
  logic [LEN_W-1:0]  slot_len    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid;

  logic [ID_W-1:0]   prev_id;
  logic [LEN_W-1:0]  prev_len;
  logic              prev_valid;
  logic [TIME_W-1:0] detect_time;
  logic [TIME_W-1:0] tap_time;
  logic              awaiting;
  logic              card_present;
  logic              cur_found;
  logic [SLOT_W-1:0] cur_index;
  logic [2:0]        led_state;
  logic [CNT_W-1:0]  stat [NUM_CNT];

  // next values
  logic              prev_write;
  logic [TIME_W-1:0] tap_time_next;
  logic              awaiting_next;
  logic              card_present_next;
  logic              cur_found_next;
  logic [SLOT_W-1:0] cur_index_next;
  logic [2:0]        led_state_next;
  logic [CNT_W-1:0]  stat_next [NUM_CNT];
  logic              slot_write;
  logic [1:0]        event_next;
  logic [1:0]        status_next;
  logic              single_next;

  // per-poll terms
  logic [LEN_W-1:0]  len_sat;
  logic [ID_W-1:0]   id_masked;
  logic [SLOT_COUNT-1:0] slot_hit;
  logic              any_hit;
  logic [SLOT_W-1:0] hit_index;
  logic [TIME_W-1:0] detect_gap;
  logic [TIME_W-1:0] tap_gap;
  logic              is_repeat;
  logic              slot_bad;
  logic [TIME_W-1:0] wait_gap;

  // lengths beyond the identifier size saturate; bytes above the length drop
  always_comb begin
    len_sat = (s1_len > LEN_MAX) ? LEN_MAX : s1_len;
    for (int b = 0; b < ID_W / 8; b++) begin
      id_masked[8*b +: 8] = (LEN_W'(b) < len_sat) ? s1_id[8*b +: 8] : 8'h00;
    end
  end

  // parallel lookup over the slot table, lowest matching slot wins
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_hit[i] = slot_valid[i] && (slot_len[i] == len_sat) &&
                    (slot_id[i] == id_masked);
    end
    any_hit   = |slot_hit;
    hit_index = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_hit[i]) begin
        hit_index = SLOT_W'(i);
      end
    end
  end

  assign detect_gap = s1_time - detect_time;
  assign tap_gap    = s1_time - tap_time;
  assign is_repeat  = prev_valid && (prev_id == id_masked) && (prev_len == len_sat) &&
                      (detect_gap < {{(TIME_W-CFG_W){1'b0}}, debounce_ms});
  assign slot_bad   = {1'b0, s1_tslot} >= (TSLOT_W+1)'(SLOT_COUNT);

  always_comb begin
    prev_write        = 1'b0;
    tap_time_next     = tap_time;
    awaiting_next     = awaiting;
    card_present_next = card_present;
    cur_found_next    = cur_found;
    cur_index_next    = cur_index;
    led_state_next    = led_state;
    slot_write        = 1'b0;
    event_next        = EV_NONE;
    status_next       = RS_NONE;
    single_next       = 1'b0;
    for (int c = 0; c < NUM_CNT; c++) begin
      stat_next[c] = stat[c];
    end

    unique case (s1_cmd)
      CMD_NO_CARD: begin
        if (card_present) begin
          card_present_next = 1'b0;
          led_state_next    = LED_OFF;
        end
      end
      CMD_CARD_READ: begin
        if (!is_repeat) begin
          card_present_next    = 1'b1;
          prev_write           = 1'b1;
          stat_next[CNT_TOTAL] = sat_inc(stat[CNT_TOTAL]);
          if (!any_hit) begin
            cur_found_next         = 1'b0;
            cur_index_next         = '0;
            stat_next[CNT_UNKNOWN] = sat_inc(stat[CNT_UNKNOWN]);
            led_state_next         = LED_RED;
            event_next             = EV_UNKNOWN;
          end else begin
            cur_found_next       = 1'b1;
            cur_index_next       = hit_index;
            stat_next[CNT_VALID] = sat_inc(stat[CNT_VALID]);
            if (awaiting && (tap_gap <= {{(TIME_W-CFG_W){1'b0}}, window_ms})) begin
              // second tap inside the window, counted once here
              awaiting_next         = 1'b0;
              stat_next[CNT_DOUBLE] = sat_inc(stat[CNT_DOUBLE]);
              led_state_next        = LED_GREEN;
              event_next            = EV_DOUBLE;
            end else begin
              awaiting_next  = 1'b1;
              tap_time_next  = s1_time;
              led_state_next = LED_BLUE;
              event_next     = EV_FIRST;
            end
          end
        end
      end
      CMD_REGISTER: begin
        if (slot_bad) begin
          status_next = RS_BAD_SLOT;
        end else if (any_hit) begin
          status_next = RS_DUPLICATE;
        end else begin
          slot_write     = 1'b1;
          led_state_next = LED_OFF;
          status_next    = RS_REGISTERED;
        end
      end
      CMD_CLEAR_STATS: begin
        for (int c = 0; c < NUM_CNT; c++) begin
          stat_next[c] = '0;
        end
      end
      default: begin
        // read failed and unused codes only run the timeout check
      end
    endcase

    // second-tap wait timeout, after the command has been applied
    wait_gap = s1_time - tap_time_next;
    if (awaiting_next && (wait_gap > {{(TIME_W-CFG_W){1'b0}}, window_ms})) begin
      awaiting_next         = 1'b0;
      stat_next[CNT_SINGLE] = sat_inc(stat_next[CNT_SINGLE]);
      led_state_next        = LED_GREEN;
      single_next           = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      prev_valid   <= 1'b0;
      awaiting     <= 1'b0;
      card_present <= 1'b0;
      cur_found    <= 1'b0;
      cur_index    <= '0;
      led_state    <= LED_OFF;
      for (int c = 0; c < NUM_CNT; c++) begin
        stat[c] <= '0;
      end
    end else if (advance) begin
      if (slot_write) begin
        slot_valid[s1_tslot[SLOT_W-1:0]] <= 1'b1;
      end
      if (prev_write) begin
        prev_valid <= 1'b1;
      end
      awaiting     <= awaiting_next;
      card_present <= card_present_next;
      cur_found    <= cur_found_next;
      cur_index    <= cur_index_next;
      led_state    <= led_state_next;
      for (int c = 0; c < NUM_CNT; c++) begin
        stat[c] <= stat_next[c];
      end
    end
  end

  // payload state, only read behind a valid flag
  always_ff @(posedge clk) begin
    if (advance) begin
      if (slot_write) begin
        slot_id[s1_tslot[SLOT_W-1:0]]  <= id_masked;
        slot_len[s1_tslot[SLOT_W-1:0]] <= len_sat;
      end
      if (prev_write) begin
        prev_id     <= id_masked;
        prev_len    <= len_sat;
        detect_time <= s1_time;
      end
      tap_time <= tap_time_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res        <= event_next;
      single_confirmed <= single_next;
      slot_found       <= cur_found_next;
      matched_slot     <= cur_found_next ? 2'(cur_index_next) : 2'b00;
      leds             <= led_state_next;
      register_status  <= status_next;
      total_reads      <= stat_next[CNT_TOTAL];
      valid_reads      <= stat_next[CNT_VALID];
      unknown_reads    <= stat_next[CNT_UNKNOWN];
      single_taps      <= stat_next[CNT_SINGLE];
      double_taps      <= stat_next[CNT_DOUBLE];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ctc_checker.sv]
// ----------------------------------------------------------------------------
// ctc_checker
// port-level assertions on the card tap classifier results
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_checker
  import ctc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       event_res,
  input wire logic             slot_found,
  input wire logic [1:0]       matched_slot,
  input wire logic [2:0]       leds,
  input wire logic [1:0]       register_status,
  input wire logic [CNT_W-1:0] total_reads,
  input wire logic [CNT_W-1:0] valid_reads,
  input wire logic [CNT_W-1:0] unknown_reads
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(leds) &&
                               $stable(total_reads))
    else $error("stalled result changed");

  // every valid or unknown read is also counted as a read
  a_totals: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_reads >= valid_reads) && (total_reads >= unknown_reads))
    else $error("read counters out of order");

  // a double tap ends any wait, so nothing can override the green led
  a_double_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_DOUBLE) |-> (leds == LED_GREEN) && slot_found)
    else $error("double tap without green led");

  // an unknown card clears the current slot
  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_UNKNOWN) |-> !slot_found && (matched_slot == 2'b00))
    else $error("unknown card reports a slot");

  // a registration poll carries no tap event
  a_reg_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && (register_status != RS_NONE) |-> (event_res == EV_NONE))
    else $error("registration with tap event");

endmodule

bind card_tap_classifier_core ctc_checker u_ctc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .event_res       (event_res),
  .slot_found      (slot_found),
  .matched_slot    (matched_slot),
  .leds            (leds),
  .register_status (register_status),
  .total_reads     (total_reads),
  .valid_reads     (valid_reads),
  .unknown_reads   (unknown_reads)
);

`default_nettype wire

[tb/card_tap_classifier_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_tap_classifier_core_tb
// self-checking regression of the card tap classifier core
// ----------------------------------------------------------------------------
// Polls are driven on the input channel and each result transfer is compared
// field by field against a behavioral model that runs inside the bench. The
// run covers directed cases (first read after reset, slot registration, the
// debounce and double tap windows, timestamp wrap, identifier masking, unused
// commands) and random traffic under several timing settings and idle/stall
// mixes.
// ----------------------------------------------------------------------------

module card_tap_classifier_core_tb
  import ctc_pkg::*;
;

  localparam int QUIET_LIMIT = 2000;
  localparam int POOL_N      = 6;
  localparam int PHASE_POLLS = 305;

  typedef struct packed {
    event_t           ev;
    logic             single;
    logic             found;
    logic [1:0]       slot;
    logic [2:0]       leds;
    reg_status_t      status;
    logic [CNT_W-1:0] n_total;
    logic [CNT_W-1:0] n_valid;
    logic [CNT_W-1:0] n_unknown;
    logic [CNT_W-1:0] n_single;
    logic [CNT_W-1:0] n_double;
  } poll_result_t;

  // clock, reset and block inputs, all known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic                 in_valid = 1'b0;
  logic [CMD_W-1:0]     command = '0;
  logic [ID_W-1:0]      card_id = '0;
  logic [LEN_W-1:0]     card_id_bytes = '0;
  logic [TIME_W-1:0]    time_ms = '0;
  logic [TSLOT_W-1:0]   target_slot = '0;
  logic                 out_stall = 1'b0;

  wire  [31:0]          prdata;
  wire                  pready;
  wire                  in_stall;
  wire                  out_valid;
  wire  [1:0]           event_res;
  wire                  single_confirmed;
  wire                  slot_found;
  wire  [1:0]           matched_slot;
  wire  [2:0]           leds;
  wire  [1:0]           register_status;
  wire  [CNT_W-1:0]     total_reads;
  wire  [CNT_W-1:0]     valid_reads;
  wire  [CNT_W-1:0]     unknown_reads;
  wire  [CNT_W-1:0]     single_taps;
  wire  [CNT_W-1:0]     double_taps;

  card_tap_classifier_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .card_id          (card_id),
    .card_id_bytes    (card_id_bytes),
    .time_ms          (time_ms),
    .target_slot      (target_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .event_res        (event_res),
    .single_confirmed (single_confirmed),
    .slot_found       (slot_found),
    .matched_slot     (matched_slot),
    .leds             (leds),
    .register_status  (register_status),
    .total_reads      (total_reads),
    .valid_reads      (valid_reads),
    .unknown_reads    (unknown_reads),
    .single_taps      (single_taps),
    .double_taps      (double_taps)
  );

  // 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // classifier model state
  // ------------------------------------------------------------------------
  logic [CFG_W-1:0]   window_cfg = WINDOW_RESET;
  logic [CFG_W-1:0]   debounce_cfg = DEBOUNCE_RESET;
  logic [ID_W-1:0]    tbl_id   [SLOT_COUNT];
  logic [LEN_W-1:0]   tbl_len  [SLOT_COUNT];
  logic               tbl_used [SLOT_COUNT] = '{default: 1'b0};
  logic [ID_W-1:0]    last_id = '0;
  logic [LEN_W-1:0]   last_len = '0;
  logic               last_seen = 1'b0;
  logic [TIME_W-1:0]  detect_ms = '0;
  logic [TIME_W-1:0]  tap_ms = '0;
  logic               waiting_second = 1'b0;
  logic               card_on = 1'b0;
  logic               cur_hit = 1'b0;
  logic [SLOT_W-1:0]  cur_slot = '0;
  logic [2:0]         led_model = LED_OFF;
  logic [CNT_W-1:0]   stats [NUM_CNT] = '{default: '0};

  // results owed by the block, oldest first
  poll_result_t       poll_results_due [$];
  poll_result_t       head_result;

  int                 fail_count = 0;
  int                 quiet_cycles = 0;
  int                 sender_idle_pct = 0;
  int                 stall_pct = 0;

  // random traffic: card pool and running clock
  logic [ID_W-1:0]    pool_id  [POOL_N];
  logic [LEN_W-1:0]   pool_len [POOL_N];
  logic [TIME_W-1:0]  sim_ms = '0;

  function automatic void bump_stat(int which);
    if (stats[which] != CNT_MAX) stats[which] = stats[which] + 1'b1;
  endfunction

  function automatic int lookup_slot(logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
    for (int i = 0; i < SLOT_COUNT; i++)
      if (tbl_used[i] && tbl_len[i] == len && tbl_id[i] == id) return i;
    return -1;
  endfunction

  // one poll through the model: updates the state, returns the owed result
  function automatic poll_result_t classify_poll(logic [CMD_W-1:0] cmd,
      logic [ID_W-1:0] raw_id, logic [LEN_W-1:0] raw_len, logic [TIME_W-1:0] now,
      logic [TSLOT_W-1:0] tslot);
    poll_result_t      r;
    logic [LEN_W-1:0]  len;
    logic [63:0]       mask;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] since_detect;
    logic [TIME_W-1:0] since_tap;
    logic              dup_read;
    int                hit;
    r = '0;
    r.ev = EV_NONE;
    r.status = RS_NONE;
    len = (raw_len > LEN_MAX) ? LEN_MAX : raw_len;
    // only the low len bytes take part in an identifier
    mask = (64'd1 << (8 * len)) - 64'd1;
    id = raw_id & mask[ID_W-1:0];
    case (cmd)
      CMD_NO_CARD: begin
        if (card_on) begin
          card_on = 1'b0;
          led_model = LED_OFF;
        end
      end
      CMD_CARD_READ: begin
        since_detect = now - detect_ms;
        dup_read = last_seen && last_id == id && last_len == len &&
                   since_detect < TIME_W'(debounce_cfg);
        if (!dup_read) begin
          card_on = 1'b1;
          detect_ms = now;
          last_id = id;
          last_len = len;
          last_seen = 1'b1;
          bump_stat(CNT_TOTAL);
          led_model = LED_BLUE;
          hit = lookup_slot(id, len);
          if (hit < 0) begin
            cur_hit = 1'b0;
            cur_slot = '0;
            bump_stat(CNT_UNKNOWN);
            led_model = LED_RED;
            r.ev = EV_UNKNOWN;
          end else begin
            cur_hit = 1'b1;
            cur_slot = SLOT_W'(hit);
            bump_stat(CNT_VALID);
            since_tap = now - tap_ms;
            if (waiting_second && since_tap <= TIME_W'(window_cfg)) begin
              waiting_second = 1'b0;
              bump_stat(CNT_DOUBLE);
              led_model = LED_GREEN;
              r.ev = EV_DOUBLE;
            end else begin
              waiting_second = 1'b1;
              tap_ms = now;
              r.ev = EV_FIRST;
            end
          end
        end
      end
      CMD_REGISTER: begin
        if (int'(tslot) >= SLOT_COUNT) begin
          r.status = RS_BAD_SLOT;
        end else if (lookup_slot(id, len) >= 0) begin
          r.status = RS_DUPLICATE;
        end else begin
          tbl_id[tslot[SLOT_W-1:0]] = id;
          tbl_len[tslot[SLOT_W-1:0]] = len;
          tbl_used[tslot[SLOT_W-1:0]] = 1'b1;
          led_model = LED_OFF;
          r.status = RS_REGISTERED;
        end
      end
      CMD_CLEAR_STATS: begin
        for (int i = 0; i < NUM_CNT; i++) stats[i] = '0;
      end
      default: ;
    endcase
    // the second-tap wait times out at the end of every poll
    since_tap = now - tap_ms;
    if (waiting_second && since_tap > TIME_W'(window_cfg)) begin
      waiting_second = 1'b0;
      bump_stat(CNT_SINGLE);
      led_model = LED_GREEN;
      r.single = 1'b1;
    end
    r.found = cur_hit;
    r.slot = cur_hit ? 2'(cur_slot) : 2'd0;
    r.leds = led_model;
    r.n_total = stats[CNT_TOTAL];
    r.n_valid = stats[CNT_VALID];
    r.n_unknown = stats[CNT_UNKNOWN];
    r.n_single = stats[CNT_SINGLE];
    r.n_double = stats[CNT_DOUBLE];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // one poll transfer; random sender gaps in front, payload held while stalled
  task automatic send_poll(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
      logic [LEN_W-1:0] len, logic [TIME_W-1:0] now, logic [TSLOT_W-1:0] tslot);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    card_id       <= id;
    card_id_bytes <= len;
    time_ms       <= now;
    target_slot   <= tslot;
    do @(posedge clk); while (in_stall);
    poll_results_due.push_back(classify_poll(cmd, id, len, now, tslot));
  endtask

  // drop valid and let every owed result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (poll_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access cycle; only issued with the block drained
  task automatic write_register(logic reg_idx, logic [CFG_W-1:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_WINDOW) window_cfg = value;
    else debounce_cfg = value;
  endtask

  // receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (poll_results_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t ns: result transfer with no poll outstanding, expected none actual %0h",
                   $time, event_res);
      end else begin
        head_result = poll_results_due.pop_front();
        check_field("event_res", head_result.ev, event_res);
        check_field("single_confirmed", head_result.single, single_confirmed);
        check_field("slot_found", head_result.found, slot_found);
        check_field("matched_slot", head_result.slot, matched_slot);
        check_field("leds", head_result.leds, leds);
        check_field("register_status", head_result.status, register_status);
        check_field("total_reads", head_result.n_total, total_reads);
        check_field("valid_reads", head_result.n_valid, valid_reads);
        check_field("unknown_reads", head_result.n_unknown, unknown_reads);
        check_field("single_taps", head_result.n_single, single_taps);
        check_field("double_taps", head_result.n_double, double_taps);
      end
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
      $display("card_tap_classifier_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  localparam logic [ID_W-1:0] CARD_A = 56'h0000_00A1_B2C3_D4;
  localparam logic [ID_W-1:0] CARD_B = '1;

  // no previous identifier, so even an empty id is accepted at once
  task automatic test_first_read_after_reset();
    send_poll(CMD_CARD_READ, '0, 3'd0, 32'd0, '0);
    // same empty id inside the debounce time is dropped
    send_poll(CMD_CARD_READ, '0, 3'd0, 32'd1, '0);
  endtask

  task automatic test_registration();
    send_poll(CMD_REGISTER, CARD_A, 3'd4, 32'd10, 4'd15);
    send_poll(CMD_REGISTER, CARD_A, 3'd4, 32'd11, TSLOT_W'(SLOT_COUNT));
    send_poll(CMD_REGISTER, CARD_A, 3'd4, 32'd12, 4'd0);
    // same id into another slot is a duplicate
    send_poll(CMD_REGISTER, CARD_A, 3'd4, 32'd13, 4'd1);
    send_poll(CMD_REGISTER, CARD_B, 3'd7, 32'd14, 4'd3);
    // empty identifier is a legal entry of its own
    send_poll(CMD_REGISTER, '1, 3'd0, 32'd15, 4'd2);
  endtask

  // default window 2000 and debounce 500 from reset
  task automatic test_tap_timing();
    send_poll(CMD_CARD_READ, CARD_A, 3'd4, 32'd1000, '0);
    send_poll(CMD_CARD_READ, CARD_A, 3'd4, 32'd1499, '0);
    send_poll(CMD_CARD_READ, CARD_A, 3'd4, 32'd1500, '0);
    send_poll(CMD_CARD_READ, CARD_A, 3'd4, 32'd3000, '0);
    // gap equal to the window keeps waiting, one more ms confirms a single
    send_poll(CMD_READ_FAILED, CARD_A, 3'd4, 32'd5000, '0);
    send_poll(CMD_READ_FAILED, CARD_A, 3'd4, 32'd5001, '0);
    send_poll(CMD_NO_CARD, '0, 3'd1, 32'd5002, '0);
    // double tap across the timestamp wrap
    send_poll(CMD_CARD_READ, CARD_B, 3'd7, 32'hFFFF_FFF0, 4'd15);
    send_poll(CMD_CARD_READ, CARD_B, 3'd7, 32'h0000_0300, 4'd15);
  endtask

  task automatic test_identifier_matching();
    // bits above the valid bytes are ignored
    send_poll(CMD_CARD_READ, CARD_A | 56'hFF_FFFF_0000_0000, 3'd4, 32'd10000, '0);
    // same bytes, one byte longer, is another card
    send_poll(CMD_CARD_READ, CARD_A, 3'd5, 32'd10001, '0);
    send_poll(CMD_CARD_READ, 56'h12_3456_789A_BCDE, 3'd0, 32'd20000, '0);
  endtask

  task automatic test_misc_commands();
    send_poll(CMD_W'(5), CARD_A, 3'd4, 32'd20001, 4'd0);
    send_poll(CMD_W'(6), CARD_A, 3'd4, 32'd20002, 4'd1);
    send_poll(CMD_W'(7), CARD_A, 3'd4, 32'd30000, 4'd2);
    send_poll(CMD_CLEAR_STATS, '0, 3'd0, 32'hFFFF_FFFF, '0);
  endtask

  // gaps aimed at the debounce and window edges, plus wild jumps
  function automatic logic [TIME_W-1:0] next_gap();
    case ($urandom_range(11))
      0: return '0;
      1: return 32'd1;
      2: return TIME_W'(debounce_cfg) - 32'd1;
      3: return TIME_W'(debounce_cfg);
      4: return TIME_W'(window_cfg);
      5: return TIME_W'(window_cfg) + 32'd1;
      6: return TIME_W'(window_cfg) - 32'd1;
      7: return TIME_W'($urandom_range(200));
      8: return TIME_W'($urandom_range(3000));
      9: return $urandom;
      default: return TIME_W'($urandom_range(2 * window_cfg + 2));
    endcase
  endfunction

  task automatic random_poll();
    int                pick;
    int                k;
    logic [63:0]       rnd;
    logic [63:0]       mask;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [TSLOT_W-1:0] tslot;
    pick = $urandom_range(99);
    if (pick < 58) cmd = CMD_CARD_READ;
    else if (pick < 70) cmd = CMD_NO_CARD;
    else if (pick < 78) cmd = CMD_READ_FAILED;
    else if (pick < 88) cmd = CMD_REGISTER;
    else if (pick < 92) cmd = CMD_CLEAR_STATS;
    else cmd = CMD_W'($urandom_range(7, 5));
    rnd = {$urandom, $urandom};
    if ($urandom_range(4) != 0) begin
      // pool card, sometimes with junk above its valid bytes
      k = $urandom_range(POOL_N - 1);
      len = pool_len[k];
      mask = (64'd1 << (8 * len)) - 64'd1;
      id = pool_id[k];
      if (rnd[63]) id = id | (rnd[ID_W-1:0] & ~mask[ID_W-1:0]);
    end else begin
      len = LEN_W'($urandom_range(7));
      id = rnd[ID_W-1:0];
    end
    if ($urandom_range(3) == 0) tslot = TSLOT_W'($urandom_range(15));
    else tslot = TSLOT_W'($urandom_range(SLOT_COUNT - 1));
    sim_ms = sim_ms + next_gap();
    send_poll(cmd, id, len, sim_ms, tslot);
  endtask

  task automatic run_phase(int idle_pct, int stall_rate, logic [CFG_W-1:0] win,
      logic [CFG_W-1:0] deb);
    write_register(REG_WINDOW, win);
    write_register(REG_DEBOUNCE, deb);
    sender_idle_pct = idle_pct;
    stall_pct = stall_rate;
    for (int i = 0; i < PHASE_POLLS; i++) random_poll();
  endtask

  task automatic test_random_traffic();
    logic [63:0] rnd;
    for (int i = 0; i < POOL_N; i++) begin
      rnd = {$urandom, $urandom};
      pool_id[i] = rnd[ID_W-1:0];
    end
    pool_len[0] = 3'd7;
    pool_len[1] = 3'd4;
    pool_len[2] = LEN_W'($urandom_range(7));
    pool_len[3] = 3'd3;
    pool_len[4] = 3'd4;
    // same bytes as the previous card, one byte longer
    pool_len[5] = 3'd5;
    pool_id[4] = {24'd0, pool_id[4][31:0]};
    pool_id[5] = pool_id[4];
    for (int i = 0; i < POOL_N; i++)
      pool_id[i] = pool_id[i] & ((56'd1 << (8 * pool_len[i])) - 56'd1);
    sim_ms = $urandom;
    // seed the table so most reads find a card
    for (int i = 0; i < SLOT_COUNT; i++)
      send_poll(CMD_REGISTER, pool_id[i], pool_len[i], sim_ms, TSLOT_W'(i));
    run_phase(0, 0, WINDOW_RESET, DEBOUNCE_RESET);
    run_phase(64, 0, '0, '0);
    run_phase(0, 64, '1, '1);
    run_phase(20, 20, CFG_W'($urandom_range(5000)), CFG_W'($urandom_range(1500)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_read_after_reset();
    test_registration();
    test_tap_timing();
    test_identifier_matching();
    test_misc_commands();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("card_tap_classifier_core regression: pass");
    end else begin
      $display("card_tap_classifier_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ctc_pkg.sv
rtl/core/card_tap_classifier_core.sv
rtl/core/ctc_checker.sv
tb/card_tap_classifier_core_tb.sv
